// ----- hw/rtl/trqs_pkg.sv -----
// shared constants, codes and types for the thread ready queue scheduler
package trqs_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_WIDTH    = 8;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);

    localparam int OP_W        = 3;
    localparam int TID_W       = 8;
    localparam int OCC_W       = 5;
    localparam int STATUS_W    = 2;
    localparam int MODE_W      = 2;
    localparam int QUANTUM_W   = 16;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int SLICE_W     = 17;

    localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd100;
    localparam logic [SLICE_W-1:0]   SLICE_MAX     = {SLICE_W{1'b1}};

    localparam logic [MODE_W-1:0] MODE_RR       = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FIFO     = 2'd1;
    localparam int                MODE_PRE_BIT  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 1'b1;

    typedef logic [ID_WIDTH-1:0] id_t;
    typedef logic [CNT_W-1:0]    cnt_t;

    typedef enum logic [OP_W-1:0] {
        OP_ADD      = 3'd0,
        OP_REMOVE   = 3'd1,
        OP_SEL_NEXT = 3'd2,
        OP_SEL_CUR  = 3'd3,
        OP_RESCHED  = 3'd4,
        OP_ZERO     = 3'd5,
        OP_DRAIN    = 3'd6
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic drain_step;
    } cmd_t;

    typedef struct packed {
        logic drain_go;
        logic drain_last;
    } stat_t;

endpackage

// ----- hw/rtl/trqs_datapath.sv -----
// ready queue cell array, slice counter, configuration and result registers
module trqs_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  trqs_pkg::cmd_t                 cmd,
    output trqs_pkg::stat_t                stat,
    input  logic                           cfg_we,
    input  logic [trqs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [trqs_pkg::CFG_W-1:0]     cfg_data,
    input  logic [trqs_pkg::OP_W-1:0]      op,
    input  logic [trqs_pkg::TID_W-1:0]     thread_id,
    output logic [trqs_pkg::TID_W-1:0]     selected_id,
    output logic                           valid_res,
    output logic                           last,
    output logic [trqs_pkg::OCC_W-1:0]     occupancy,
    output logic [trqs_pkg::STATUS_W-1:0]  status
);
    import trqs_pkg::*;

    op_t                    op_reg;
    id_t                    id_reg;
    logic [MODE_W-1:0]      mode_reg;
    logic [QUANTUM_W-1:0]   quantum_reg;
    id_t                    slot_reg [QUEUE_DEPTH];
    id_t                    slot_next [QUEUE_DEPTH];
    id_t                    up [QUEUE_DEPTH];
    id_t                    down [QUEUE_DEPTH];
    cnt_t                   count_reg, count_next;
    logic [SLICE_W-1:0]     slice_reg, slice_next;

    id_t                    sel_reg, sel_next;
    logic                   valid_reg, valid_next;
    logic                   last_reg;
    cnt_t                   occ_reg;
    status_t                status_reg, status_next;

    logic                   pre, fifo, empty, full, found, rot_sel;
    logic                   do_add, do_remove, do_rotate, do_swap;
    cnt_t                   cnt_m1, cnt_m2;
    logic [IDX_W-1:0]       tail_idx;
    id_t                    tail_id;
    logic [QUEUE_DEPTH-1:0] match, covered;

    // neighbor taps of the cell chain
    for (genvar g = 0; g < QUEUE_DEPTH; g++)
    begin : g_tap
        if (g < QUEUE_DEPTH - 1)
        begin : g_up
            assign up[g] = slot_reg[g+1];
        end
        else
        begin : g_up_end
            assign up[g] = slot_reg[g];
        end
        if (g > 0)
        begin : g_down
            assign down[g] = slot_reg[g-1];
        end
        else
        begin : g_down_end
            assign down[g] = slot_reg[g];
        end
    end

    assign pre      = mode_reg[MODE_PRE_BIT];
    assign fifo     = !pre && (mode_reg == MODE_FIFO);
    assign empty    = (count_reg == '0);
    assign full     = (count_reg >= CNT_W'(QUEUE_DEPTH));
    assign cnt_m1   = count_reg - 1'b1;
    assign cnt_m2   = cnt_m1 - 1'b1;
    assign tail_idx = cnt_m1[IDX_W-1:0];
    assign tail_id  = slot_reg[tail_idx];
    assign found    = |match;
    assign rot_sel  = (op_reg == OP_SEL_NEXT) && !pre && !fifo && !empty
                      && (slice_reg > SLICE_W'(quantum_reg));

    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            match[i]   = (CNT_W'(i) < count_reg) && (slot_reg[i] == id_reg);
            covered[i] = |(match & ({QUEUE_DEPTH{1'b1}} >> (QUEUE_DEPTH - 1 - i)));
        end
    end

    // operation decode
    always_comb
    begin
        count_next  = count_reg;
        slice_next  = slice_reg;
        sel_next    = '0;
        valid_next  = 1'b0;
        status_next = ST_OK;
        do_add      = 1'b0;
        do_remove   = 1'b0;
        do_rotate   = 1'b0;
        do_swap     = 1'b0;
        unique case (op_reg) inside
            OP_ADD:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    do_add     = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (found)
                begin
                    do_remove  = 1'b1;
                    count_next = cnt_m1;
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            OP_SEL_NEXT, OP_SEL_CUR:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    valid_next = 1'b1;
                    if (pre)
                    begin
                        sel_next = tail_id;
                    end
                    else
                    begin
                        if (rot_sel)
                        begin
                            do_rotate = 1'b1;
                            sel_next  = (count_reg >= CNT_W'(2)) ? slot_reg[1] : slot_reg[0];
                        end
                        else
                        begin
                            sel_next = slot_reg[0];
                        end
                        if ((op_reg == OP_SEL_NEXT) && !fifo)
                        begin
                            if (rot_sel)
                            begin
                                slice_next = SLICE_W'(1);
                            end
                            else if (slice_reg != SLICE_MAX)
                            begin
                                slice_next = slice_reg + 1'b1;
                            end
                        end
                    end
                end
            end
            OP_RESCHED:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else if (pre)
                begin
                    do_swap = (count_reg >= CNT_W'(2));
                end
                else
                begin
                    do_rotate = 1'b1;
                    if (!fifo)
                    begin
                        slice_next = '0;
                    end
                end
            end
            OP_ZERO:
            begin
                slice_next = '0;
            end
            OP_DRAIN:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
            end
            default:
            begin
            end
        endcase
    end

    // per-cell next value
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            slot_next[i] = slot_reg[i];
            if (cmd.drain_step)
            begin
                slot_next[i] = up[i];
            end
            else if (cmd.exec)
            begin
                if (do_add && (CNT_W'(i) == count_reg))
                begin
                    slot_next[i] = id_reg;
                end
                if (do_remove && covered[i])
                begin
                    slot_next[i] = up[i];
                end
                if (do_rotate)
                begin
                    if (CNT_W'(i) == cnt_m1)
                    begin
                        slot_next[i] = slot_reg[0];
                    end
                    else if (CNT_W'(i) < cnt_m1)
                    begin
                        slot_next[i] = up[i];
                    end
                end
                if (do_swap)
                begin
                    if (CNT_W'(i) == cnt_m1)
                    begin
                        slot_next[i] = down[i];
                    end
                    else if (CNT_W'(i) == cnt_m2)
                    begin
                        slot_next[i] = up[i];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            slice_reg   <= '0;
            mode_reg    <= MODE_RR;
            quantum_reg <= QUANTUM_RESET;
        end
        else
        begin
            if (cfg_we && (cfg_index == CFG_MODE))
            begin
                mode_reg <= cfg_data[MODE_W-1:0];
            end
            if (cfg_we && (cfg_index == CFG_QUANTUM))
            begin
                quantum_reg <= cfg_data[QUANTUM_W-1:0];
            end
            if (cmd.exec)
            begin
                count_reg <= count_next;
                slice_reg <= slice_next;
            end
            else if (cmd.drain_step)
            begin
                count_reg <= cnt_m1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg <= op_t'(op);
            id_reg <= id_t'(thread_id);
        end
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            slot_reg[i] <= slot_next[i];
        end
        if (cmd.exec)
        begin
            sel_reg    <= sel_next;
            valid_reg  <= valid_next;
            last_reg   <= 1'b1;
            occ_reg    <= count_next;
            status_reg <= status_next;
        end
        else if (cmd.drain_step)
        begin
            sel_reg    <= slot_reg[0];
            valid_reg  <= 1'b1;
            last_reg   <= (count_reg == CNT_W'(1));
            occ_reg    <= '0;
            status_reg <= ST_OK;
        end
    end

    assign stat.drain_go   = (op_reg == OP_DRAIN) && !empty;
    assign stat.drain_last = (count_reg == CNT_W'(1));

    assign selected_id = TID_W'(sel_reg);
    assign valid_res   = valid_reg;
    assign last        = last_reg;
    assign occupancy   = OCC_W'(occ_reg);
    assign status      = STATUS_W'(status_reg);

endmodule

// ----- hw/rtl/trqs_controller.sv -----
// sequencing state machine and handshake control for the scheduler
module trqs_controller (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  trqs_pkg::stat_t stat,
    output trqs_pkg::cmd_t  cmd
);
    import trqs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DRAIN
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.drain_go)
                begin
                    state_next = S_DRAIN;
                end
                else if (out_free)
                begin
                    cmd.exec       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_DRAIN:
            begin
                if (out_free)
                begin
                    cmd.drain_step = 1'b1;
                    out_valid_next = 1'b1;
                    if (stat.drain_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- hw/rtl/thread_ready_queue_scheduler.sv -----
// top level of the thread ready queue scheduler
// An operation is captured on input transfer, then run across the cell array into the
// result registers once the output register is free, so no new item is taken before
// the last has run; a result waits in the output register while the next is taken. A
// drain of n queued entries gives n results, one per cycle while the output is free.
// The queue contents are undefined after reset but are never read before written.
module thread_ready_queue_scheduler (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [trqs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [trqs_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [trqs_pkg::OP_W-1:0]      op,
    input  logic [trqs_pkg::TID_W-1:0]     thread_id,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [trqs_pkg::TID_W-1:0]     selected_id,
    output logic                           valid_res,
    output logic                           last,
    output logic [trqs_pkg::OCC_W-1:0]     occupancy,
    output logic [trqs_pkg::STATUS_W-1:0]  status
);
    import trqs_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    trqs_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    trqs_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .op          (op),
        .thread_id   (thread_id),
        .selected_id (selected_id),
        .valid_res   (valid_res),
        .last        (last),
        .occupancy   (occupancy),
        .status      (status)
    );

endmodule

// ----- hw/rtl/trqs_checker.sv -----
// port-level checks for the thread ready queue scheduler, bound to the top level
module trqs_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [trqs_pkg::TID_W-1:0]     selected_id,
    input logic                           valid_res,
    input logic [trqs_pkg::OCC_W-1:0]     occupancy,
    input logic [trqs_pkg::STATUS_W-1:0]  status
);
    import trqs_pkg::*;

    // a new input is not taken in the cycle right after a transfer
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken twice in a row");

    a_occ: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (occupancy <= OCC_W'(QUEUE_DEPTH)))
        else $error("occupancy beyond queue depth");

    a_err_novalid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_OK)) |-> !valid_res)
        else $error("error status with a valid entry");

    a_nosel_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !valid_res) |-> (selected_id == '0))
        else $error("selected id not zero without a selection");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(selected_id)))
        else $error("stalled result dropped or changed");

endmodule

bind thread_ready_queue_scheduler trqs_checker u_chk (.*);
